/* hw/rtl/ppc_pkg.sv */
`default_nettype none

package ppc_pkg;

   // Register indexes on the csr port
   localparam logic [2:0] CSR_SOURCE_WIDTH  = 3'd0;
   localparam logic [2:0] CSR_SOURCE_HEIGHT = 3'd1;
   localparam logic [2:0] CSR_TARGET_WIDTH  = 3'd2;
   localparam logic [2:0] CSR_TARGET_HEIGHT = 3'd3;
   localparam logic [2:0] CSR_ROW_PITCH     = 3'd4;
   localparam logic [2:0] CSR_BPP           = 3'd5;

   // Input command codes
   localparam logic CMD_PALETTE = 1'b0;
   localparam logic CMD_PIXEL   = 1'b1;

   // Depth codes and pixel sizes
   localparam logic [7:0] BPP_RGB565 = 8'd16;
   localparam logic [7:0] BPP_BGR24  = 8'd24;
   localparam logic [2:0] BYTES_RGB565 = 3'd2;
   localparam logic [2:0] BYTES_BGR24  = 3'd3;
   localparam logic [2:0] BYTES_XRGB   = 3'd4;
   localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;
   localparam logic [4:0] DEFAULT_DIVISOR = 5'd4;
   localparam logic [12:0] MAX_SOURCE_SIZE = 13'd4096;

   localparam int ADDR_W  = 27;
   localparam int PITCH_W = 15;
   localparam int SIZE_W  = 13;
   localparam int COUNT_W = 12;

   typedef struct packed {
      logic [SIZE_W-1:0]  source_width;
      logic [SIZE_W-1:0]  source_height;
      logic [SIZE_W-1:0]  target_width;
      logic [SIZE_W-1:0]  target_height;
      logic [PITCH_W-1:0] row_pitch_bytes;
      logic [7:0]         bits_per_pixel;
   } cfg_type;

   typedef struct packed {
      logic [SIZE_W-1:0]  sw;       // clamped source width
      logic [SIZE_W-1:0]  sh;       // clamped source height
      logic [SIZE_W-1:0]  copy_w;
      logic [SIZE_W-1:0]  copy_h;
      logic [COUNT_W-1:0] ox;
      logic [ADDR_W-1:0]  oy_addr;  // byte offset of the first copied row
      logic [2:0]         nbytes;
   } geom_type;

endpackage

`default_nettype wire

/* hw/rtl/ppc_ram.sv */
`default_nettype none

module ppc_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

/* hw/rtl/ppc_geom.sv */
`default_nettype none

module ppc_geom
   import ppc_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   input  wire cfg_type cfg,
   output logic         busy,
   output geom_type     geom
);

   typedef enum logic [2:0] {
      G_LOAD,
      G_DIV,
      G_SIZE,
      G_MUL,
      G_IDLE
   } geom_state_type;

   geom_state_type     state_ff, state_in;
   logic [3:0]         step_ff, step_in;
   logic [4:0]         div_ff, div_in;
   logic [4:0]         rem_ff, rem_in;
   logic [PITCH_W-1:0] quo_ff, quo_in;
   logic [COUNT_W-1:0] oy_ff, oy_in;
   geom_type           geom_ff, geom_in;

   logic [5:0]         shifted;
   logic [4:0]         raw_div;
   logic [SIZE_W-1:0]  swc, shc, fbw, cw, ch;
   logic [SIZE_W-1:0]  dw, dh;

   assign raw_div = cfg.bits_per_pixel[7:3];

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      div_in   = div_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      oy_in    = oy_ff;
      geom_in  = geom_ff;
      shifted  = {rem_ff, quo_ff[PITCH_W-1]};
      swc = cfg.source_width;
      if (cfg.source_width == '0) swc = 13'd1;
      else if (cfg.source_width > MAX_SOURCE_SIZE) swc = MAX_SOURCE_SIZE;
      shc = cfg.source_height;
      if (cfg.source_height == '0) shc = 13'd1;
      else if (cfg.source_height > MAX_SOURCE_SIZE) shc = MAX_SOURCE_SIZE;
      // quo_ff holds pitch / divisor once the divide is through
      fbw = ({2'b00, cfg.target_width} < quo_ff) ? cfg.target_width : quo_ff[SIZE_W-1:0];
      cw  = (swc < fbw) ? swc : fbw;
      ch  = (shc < cfg.target_height) ? shc : cfg.target_height;
      dw  = fbw - cw;
      dh  = cfg.target_height - ch;

      case (state_ff)
         G_LOAD: begin
            div_in   = (raw_div == '0) ? DEFAULT_DIVISOR : raw_div;
            rem_in   = '0;
            quo_in   = cfg.row_pitch_bytes;
            step_in  = '0;
            state_in = G_DIV;
         end
         G_DIV: begin
            // restoring divide, one quotient bit a cycle
            if (shifted >= {1'b0, div_ff}) begin
               rem_in = 5'(shifted - {1'b0, div_ff});
               quo_in = {quo_ff[PITCH_W-2:0], 1'b1};
            end else begin
               rem_in = shifted[4:0];
               quo_in = {quo_ff[PITCH_W-2:0], 1'b0};
            end
            step_in = step_ff + 4'd1;
            if (step_ff == 4'(PITCH_W - 1)) begin
               state_in = G_SIZE;
            end
         end
         G_SIZE: begin
            geom_in.sw     = swc;
            geom_in.sh     = shc;
            geom_in.copy_w = cw;
            geom_in.copy_h = ch;
            geom_in.ox     = dw[SIZE_W-1:1];
            oy_in          = dh[SIZE_W-1:1];
            if (cfg.bits_per_pixel == BPP_RGB565) geom_in.nbytes = BYTES_RGB565;
            else if (cfg.bits_per_pixel == BPP_BGR24) geom_in.nbytes = BYTES_BGR24;
            else geom_in.nbytes = BYTES_XRGB;
            state_in = G_MUL;
         end
         G_MUL: begin
            geom_in.oy_addr = ADDR_W'(oy_ff) * ADDR_W'(cfg.row_pitch_bytes);
            state_in = G_IDLE;
         end
         G_IDLE: begin
            state_in = G_IDLE;
         end
         default: begin
            state_in = G_LOAD;
         end
      endcase

      if (start) begin
         state_in = G_LOAD;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= G_LOAD;
      end else begin
         state_ff <= state_in;
      end
      step_ff <= step_in;
      div_ff  <= div_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      oy_ff   <= oy_in;
      geom_ff <= geom_in;
   end

   assign busy = (state_ff != G_IDLE);
   assign geom = geom_ff;

endmodule

`default_nettype wire

/* hw/rtl/palette_pixel_converter.sv */
`default_nettype none

// Palette pixel converter.
// req channel: one transaction is either a palette write (req_tuser low) that
// loads an RGB entry, or one indexed source pixel (req_tuser high) in raster
// order. rsp channel: one framebuffer write per source pixel that lands inside
// the centered copy region; palette writes and cropped pixels give nothing.
// rsp_tlast marks the last written pixel of a frame.
// csr channel: register writes (source size, target size, pitch, depth),
// taken at any time but meant for an idle block. Each write, and reset,
// starts a geometry pass (a load step, a bit-serial pitch divide, a sizing
// step and a multiply); req_tready stays low during it.
// Path: an accepted pixel reads the palette RAM into the read stage, then
// moves into the output register once that register is empty or drained.
// Throughput: one transaction per cycle while no geometry pass runs and the
// output is not stalled, limited by the single read port of the palette RAM.
// A palette write is visible to a pixel accepted in the very next cycle.
// When the receiver stalls, one more pixel is accepted into the RAM read
// stage, then req_tready drops until rsp drains.
// Reset: counters return to the frame start, registers to 640x480 source,
// 640x480 target, 2560-byte pitch, 32 bpp; palette contents are not cleared.

module palette_pixel_converter
   import ppc_pkg::*;
#(
   parameter int PALETTE_ENTRIES = 256
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,   // color_index, red, green, blue
   input  wire logic        req_tuser,   // command
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [63:0]      rsp_tdata,   // byte_address, pixel_data, byte_count, zero pad
   output logic             rsp_tlast,   // frame_done
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [2:0]  csr_index,
   input  wire logic [14:0] csr_data
);

   localparam int PAL_AW = $clog2(PALETTE_ENTRIES);

   // configuration registers
   cfg_type  cfg_ff, cfg_in;
   logic     csr_write;

   geom_type geom;
   logic     geom_busy;

   // frame position
   logic [COUNT_W-1:0] col_ff, col_in;
   logic [COUNT_W-1:0] row_ff, row_in;
   logic [ADDR_W-1:0]  row_start_ff, row_start_in;

   // palette RAM read stage
   logic               s1_valid_ff, s1_valid_in;
   logic [ADDR_W-1:0]  s1_base_ff;
   logic [PITCH_W-1:0] s1_off_ff;
   logic               s1_last_ff;
   logic               s1_go;

   // output register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [ADDR_W-1:0]  rsp_addr_ff;
   logic [31:0]        rsp_data_ff;
   logic [2:0]         rsp_count_ff;
   logic               rsp_last_ff;

   logic               accept, pix_accept, pal_accept;
   logic [7:0]         idx;
   logic               idx_ok;
   logic [PAL_AW-1:0]  pal_addr;
   logic [23:0]        pal_q;
   logic               frame_start, col_end, row_end, emit, last;
   logic [ADDR_W-1:0]  cur_base;
   logic [SIZE_W-1:0]  col_x, row_x, off_pix;
   logic [PITCH_W-1:0] off_bytes;
   logic [31:0]        pix_data;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid & csr_ready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_SOURCE_WIDTH:  cfg_in.source_width    = csr_data[SIZE_W-1:0];
            CSR_SOURCE_HEIGHT: cfg_in.source_height   = csr_data[SIZE_W-1:0];
            CSR_TARGET_WIDTH:  cfg_in.target_width    = csr_data[SIZE_W-1:0];
            CSR_TARGET_HEIGHT: cfg_in.target_height   = csr_data[SIZE_W-1:0];
            CSR_ROW_PITCH:     cfg_in.row_pitch_bytes = csr_data;
            CSR_BPP:           cfg_in.bits_per_pixel  = csr_data[7:0];
            default:           cfg_in = cfg_ff;   // drop writes to unknown indexes
         endcase
      end
   end

   ppc_geom u_geom (
      .clock (clock),
      .reset (reset),
      .start (csr_write),
      .cfg   (cfg_ff),
      .busy  (geom_busy),
      .geom  (geom)
   );

   // handshake: advance the read stage when the output register frees up
   assign s1_go      = s1_valid_ff & (~rsp_valid_ff | rsp_tready);
   assign req_tready = ~geom_busy & (~s1_valid_ff | s1_go);
   assign accept     = req_tvalid & req_tready;
   assign pix_accept = accept & (req_tuser == CMD_PIXEL);
   assign pal_accept = accept & (req_tuser == CMD_PALETTE);

   // out-of-range indexes: drop the write, read entry zero
   assign idx      = req_tdata[7:0];
   assign idx_ok   = ({1'b0, idx} < 9'(PALETTE_ENTRIES));
   assign pal_addr = idx_ok ? idx[PAL_AW-1:0] : '0;

   ppc_ram #(
      .WIDTH (24),
      .DEPTH (PALETTE_ENTRIES)
   ) u_palette (
      .clock   (clock),
      .wr_en   (pal_accept & idx_ok),
      .wr_addr (pal_addr),
      .wr_data ({req_tdata[15:8], req_tdata[23:16], req_tdata[31:24]}),
      .rd_en   (pix_accept),
      .rd_addr (pal_addr),
      .rd_data (pal_q)
   );

   // position and address of the incoming pixel
   always_comb begin
      col_x       = {1'b0, col_ff};
      row_x       = {1'b0, row_ff};
      frame_start = (col_ff == '0) && (row_ff == '0);
      cur_base    = frame_start ? geom.oy_addr : row_start_ff;
      emit        = (col_x < geom.copy_w) && (row_x < geom.copy_h);
      last        = (col_x + 13'd1 == geom.copy_w) && (row_x + 13'd1 == geom.copy_h);
      col_end     = (col_x + 13'd1 >= geom.sw);
      row_end     = (row_x + 13'd1 >= geom.sh);
      off_pix     = {1'b0, geom.ox} + col_x;
      case (geom.nbytes)
         BYTES_RGB565: off_bytes = {1'b0, off_pix, 1'b0};
         BYTES_BGR24:  off_bytes = {1'b0, off_pix, 1'b0} + {2'b00, off_pix};
         default:      off_bytes = {off_pix, 2'b00};
      endcase

      col_in       = col_ff;
      row_in       = row_ff;
      row_start_in = row_start_ff;
      if (pix_accept) begin
         row_start_in = cur_base;
         if (col_end) begin
            col_in = '0;
            if (row_end) begin
               row_in = '0;
            end else begin
               row_in       = row_ff + 12'd1;
               row_start_in = cur_base + ADDR_W'(cfg_ff.row_pitch_bytes);
            end
         end else begin
            col_in = col_ff + 12'd1;
         end
      end

      if (pix_accept & emit) s1_valid_in = 1'b1;
      else if (s1_go) s1_valid_in = 1'b0;
      else s1_valid_in = s1_valid_ff;

      if (s1_go) rsp_valid_in = 1'b1;
      else if (rsp_tready) rsp_valid_in = 1'b0;
      else rsp_valid_in = rsp_valid_ff;
   end

   // color conversion of the palette entry
   always_comb begin
      case (geom.nbytes)
         BYTES_RGB565: pix_data = {16'h0000, pal_q[23:19], pal_q[15:10], pal_q[7:3]};
         BYTES_BGR24:  pix_data = {8'h00, pal_q};
         default:      pix_data = {ALPHA_OPAQUE, pal_q};
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.source_width    <= 13'd640;
         cfg_ff.source_height   <= 13'd480;
         cfg_ff.target_width    <= 13'd640;
         cfg_ff.target_height   <= 13'd480;
         cfg_ff.row_pitch_bytes <= 15'd2560;
         cfg_ff.bits_per_pixel  <= 8'd32;
         col_ff       <= '0;
         row_ff       <= '0;
         row_start_ff <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         row_start_ff <= row_start_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (pix_accept) begin
         s1_base_ff <= cur_base;
         s1_off_ff  <= off_bytes;
         s1_last_ff <= last;
      end
      if (s1_go) begin
         rsp_addr_ff  <= s1_base_ff + ADDR_W'(s1_off_ff);
         rsp_data_ff  <= pix_data;
         rsp_count_ff <= geom.nbytes;
         rsp_last_ff  <= s1_last_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_count_ff, rsp_data_ff, rsp_addr_ff};
   assign rsp_tlast  = rsp_last_ff;

`ifndef SYNTHESIS
   // a register write restarts the geometry pass and holds off pixels
   a_csr_blocks_req: assert property (@(posedge clock) disable iff (reset)
      csr_write |=> !req_tready)
      else $error("req_tready high right after a register write");

   // full read stage behind a stalled output must stop the input
   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && rsp_valid_ff && !rsp_tready) |-> !req_tready)
      else $error("input accepted while both stages are full and stalled");

   // every result carries a legal byte count
   a_byte_count: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[61:59] == BYTES_RGB565 ||
                      rsp_tdata[61:59] == BYTES_BGR24 ||
                      rsp_tdata[61:59] == BYTES_XRGB))
      else $error("result with illegal byte count");
`endif

endmodule

`default_nettype wire
